[hw/rtl/sld_pkg.sv]
// Shared types, codes and the reset link pattern of the static list block.
`timescale 1ns / 1ps
package sld_pkg;

  localparam int PoolSizeDef = 64;
  localparam int SlotW       = 6;
  localparam int ValueW      = 32;
  localparam int ModeW       = 2;
  localparam int StatusW     = 3;

  localparam logic [ModeW-1:0] ModeAppend = 2'd0;
  localparam logic [ModeW-1:0] ModeToggle = 2'd1;
  localparam logic [ModeW-1:0] ModeRead   = 2'd2;

  typedef enum logic [StatusW-1:0] {
    ST_APPENDED = 3'd0,
    ST_INSERTED = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_ITEM     = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD0,
    S_A_GET0,
    S_A_GETI,
    S_A_GETT,
    S_A_LINK,
    S_T_RDT,
    S_T_STOP,
    S_T_K,
    S_T_CMP,
    S_T_RM1,
    S_T_RM2,
    S_R_0,
    S_R_K,
    S_R_EMIT,
    S_EMIT
  } state_t;

  // Link held by a slot right after reset: slot 0 heads the free chain at 2,
  // slot 1 (list head) is empty, free slots chain upward, the last ends it.
  function automatic logic [SlotW-1:0] reset_link(input int unsigned idx,
                                                  input int unsigned pool);
    logic [SlotW-1:0] res;
    res = '0;
    if (idx == 0) begin
      res = SlotW'(2);
    end else if (idx == 1) begin
      res = '0;
    end else if (idx + 1 < pool) begin
      res = SlotW'(idx + 1);
    end
    return res;
  endfunction

endpackage

[hw/rtl/sld_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps
module sld_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/sld_link_mem.sv]
// Link store: RAM plus per-slot valid bits that stand in for the reset chain.
`timescale 1ns / 1ps
module sld_link_mem #(
  parameter int DEPTH = sld_pkg::PoolSizeDef
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [$clog2(DEPTH)-1:0] wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [$clog2(DEPTH)-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [DEPTH-1:0] valid_r;
  logic             rvalid_r;
  logic [AW-1:0]    raddr_r;
  logic [AW-1:0]    ram_q;
  logic [AW-1:0]    rst_q;

  sld_ram #(
    .WIDTH (AW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rvalid_r <= valid_r[raddr];
      raddr_r  <= raddr;
    end
  end

  always_comb begin
    logic [sld_pkg::SlotW-1:0] full;
    full  = sld_pkg::reset_link(int'(raddr_r), DEPTH);
    rst_q = full[AW-1:0];
  end

  assign rdata = rvalid_r ? ram_q : rst_q;

endmodule

[hw/rtl/static_list_symmetric_difference.sv]
// Top level: array-backed linked list with free chain, symmetric difference.
//
// Input channel (in_valid/in_ready, in_mode, in_value): one beat is one
// command. Mode 0 appends a value after the tail of the first set, mode 1
// toggles a value within the first set (remove on match, else insert just
// after that tail), mode 2 reads the whole list out, mode 3 is dropped.
// Result channel (out_valid/out_ready): status, slot, elem_value, last.
// Append and toggle give one beat; read-out gives one beat per list node
// (or one "list empty" beat), last marks the final beat of a command.
// A single shared sequencer walks the link RAM, one node access a cycle
// while it is not held on a full output register. Append allocates the
// free-chain head and links it after the tail; toggle reads the tail link,
// compares the nodes of the first set in turn, then allocates or unlinks;
// read-out emits one beat per node. The link RAM has a single read port.
// in_ready is high only while the sequencer is idle.
// A finished beat sits in the output register, so the next command is taken
// while it waits. If the receiver stalls, read-out pauses on the held beat.
// Reset (rst_n, synchronous, low) restores the free chain at once through
// per-slot valid bits; no clearing pass is needed. Pool full drops the item.
`timescale 1ns / 1ps
module static_list_symmetric_difference #(
  parameter int POOL_SIZE = sld_pkg::PoolSizeDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sld_pkg::ModeW-1:0]     in_mode,
  input  logic signed [sld_pkg::ValueW-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sld_pkg::StatusW-1:0]   out_status,
  output logic [sld_pkg::SlotW-1:0]     out_slot,
  output logic signed [sld_pkg::ValueW-1:0] out_elem_value,
  output logic                          out_last
);

  localparam int AW = $clog2(POOL_SIZE);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] PoolC    = CW'(POOL_SIZE);
  localparam logic [CW-1:0] RdLastC  = CW'(POOL_SIZE - 3);
  localparam logic [AW-1:0] HeadSlot = AW'(1);
  localparam logic [AW-1:0] FreeSlot = AW'(0);

  // Sequencer state and working registers
  sld_pkg::state_t  state_r, state_nxt;
  logic [sld_pkg::ModeW-1:0]  mode_r, mode_nxt;
  logic [sld_pkg::ValueW-1:0] v_r, v_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [AW-1:0]    k_r, k_nxt;
  logic [AW-1:0]    p_r, p_nxt;
  logic [AW-1:0]    stop_r, stop_nxt;
  logic [CW-1:0]    n_r, n_nxt;
  sld_pkg::status_t res_r, res_nxt;

  // Output register
  logic                       out_valid_r, out_valid_nxt;
  sld_pkg::status_t           ost_r, ost_nxt;
  logic [AW-1:0]              oslot_r, oslot_nxt;
  logic [sld_pkg::ValueW-1:0] oval_r, oval_nxt;
  logic                       olast_r, olast_nxt;

  // Memory ports
  logic          lk_we, lk_re;
  logic [AW-1:0] lk_waddr, lk_wdata, lk_raddr, lk_rdata;
  logic          vl_we, vl_re;
  logic [AW-1:0] vl_waddr, vl_raddr;
  logic [sld_pkg::ValueW-1:0] vl_rdata;

  logic out_free;
  logic load;
  logic [CW-1:0] n_inc;
  logic          rd_last;

  sld_link_mem #(
    .DEPTH (POOL_SIZE)
  ) u_link (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (lk_re),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  // node values: undefined until a slot is allocated
  sld_ram #(
    .WIDTH (sld_pkg::ValueW),
    .DEPTH (POOL_SIZE)
  ) u_value (
    .clk   (clk),
    .we    (vl_we),
    .waddr (vl_waddr),
    .wdata (v_r),
    .re    (vl_re),
    .raddr (vl_raddr),
    .rdata (vl_rdata)
  );

  assign out_free = !out_valid_r || out_ready;
  assign n_inc    = n_r + CW'(1);
  assign rd_last  = (lk_rdata == '0) || (n_r == RdLastC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sld_pkg::S_IDLE;
      tail_r      <= HeadSlot;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    v_r     <= v_nxt;
    k_r     <= k_nxt;
    p_r     <= p_nxt;
    stop_r  <= stop_nxt;
    n_r     <= n_nxt;
    res_r   <= res_nxt;
    ost_r   <= ost_nxt;
    oslot_r <= oslot_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    v_nxt     = v_r;
    tail_nxt  = tail_r;
    k_nxt     = k_r;
    p_nxt     = p_r;
    stop_nxt  = stop_r;
    n_nxt     = n_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    load      = 1'b0;
    ost_nxt   = ost_r;
    oslot_nxt = oslot_r;
    oval_nxt  = oval_r;
    olast_nxt = olast_r;
    lk_we     = 1'b0;
    lk_waddr  = '0;
    lk_wdata  = '0;
    lk_re     = 1'b0;
    lk_raddr  = '0;
    vl_we     = 1'b0;
    vl_waddr  = k_r;
    vl_re     = 1'b0;
    vl_raddr  = '0;

    case (state_r)
      sld_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt = in_mode;
          v_nxt    = in_value;
          case (in_mode)
            sld_pkg::ModeAppend: state_nxt = sld_pkg::S_A_RD0;
            sld_pkg::ModeToggle: state_nxt = sld_pkg::S_T_RDT;
            sld_pkg::ModeRead:   state_nxt = sld_pkg::S_R_0;
            default:             state_nxt = sld_pkg::S_IDLE;
          endcase
        end
      end

      // allocate a free slot and link it after the tail
      sld_pkg::S_A_RD0: begin
        lk_re     = 1'b1;
        lk_raddr  = FreeSlot;
        state_nxt = sld_pkg::S_A_GET0;
      end
      sld_pkg::S_A_GET0: begin
        if (lk_rdata == '0) begin
          res_nxt   = sld_pkg::ST_FULL;
          k_nxt     = '0;
          state_nxt = sld_pkg::S_EMIT;
        end else begin
          k_nxt     = lk_rdata;
          lk_re     = 1'b1;
          lk_raddr  = lk_rdata;
          state_nxt = sld_pkg::S_A_GETI;
        end
      end
      sld_pkg::S_A_GETI: begin
        lk_we     = 1'b1;
        lk_waddr  = FreeSlot;
        lk_wdata  = lk_rdata;
        lk_re     = 1'b1;
        lk_raddr  = tail_r;
        state_nxt = sld_pkg::S_A_GETT;
      end
      sld_pkg::S_A_GETT: begin
        lk_we     = 1'b1;
        lk_waddr  = k_r;
        lk_wdata  = lk_rdata;
        vl_we     = 1'b1;
        state_nxt = sld_pkg::S_A_LINK;
      end
      sld_pkg::S_A_LINK: begin
        lk_we    = 1'b1;
        lk_waddr = tail_r;
        lk_wdata = k_r;
        if (mode_r == sld_pkg::ModeAppend) begin
          tail_nxt = k_r;
          res_nxt  = sld_pkg::ST_APPENDED;
        end else begin
          res_nxt  = sld_pkg::ST_INSERTED;
        end
        state_nxt = sld_pkg::S_EMIT;
      end

      // toggle: search head..tail for the value
      sld_pkg::S_T_RDT: begin
        lk_re     = 1'b1;
        lk_raddr  = tail_r;
        state_nxt = sld_pkg::S_T_STOP;
      end
      sld_pkg::S_T_STOP: begin
        stop_nxt  = lk_rdata;
        p_nxt     = HeadSlot;
        n_nxt     = '0;
        lk_re     = 1'b1;
        lk_raddr  = HeadSlot;
        state_nxt = sld_pkg::S_T_K;
      end
      sld_pkg::S_T_K: begin
        if (lk_rdata == stop_r || lk_rdata < AW'(2)) begin
          state_nxt = sld_pkg::S_A_RD0;
        end else begin
          k_nxt     = lk_rdata;
          lk_re     = 1'b1;
          lk_raddr  = lk_rdata;
          vl_re     = 1'b1;
          vl_raddr  = lk_rdata;
          state_nxt = sld_pkg::S_T_CMP;
        end
      end
      sld_pkg::S_T_CMP: begin
        if (vl_rdata == v_r) begin
          // unlink: predecessor skips the node
          lk_we     = 1'b1;
          lk_waddr  = p_r;
          lk_wdata  = lk_rdata;
          lk_re     = 1'b1;
          lk_raddr  = FreeSlot;
          state_nxt = sld_pkg::S_T_RM1;
        end else begin
          p_nxt = k_r;
          n_nxt = n_inc;
          if (lk_rdata == stop_r || lk_rdata < AW'(2) || n_inc >= PoolC) begin
            state_nxt = sld_pkg::S_A_RD0;
          end else begin
            k_nxt    = lk_rdata;
            lk_re    = 1'b1;
            lk_raddr = lk_rdata;
            vl_re    = 1'b1;
            vl_raddr = lk_rdata;
          end
        end
      end
      sld_pkg::S_T_RM1: begin
        lk_we     = 1'b1;
        lk_waddr  = k_r;
        lk_wdata  = lk_rdata;
        state_nxt = sld_pkg::S_T_RM2;
      end
      sld_pkg::S_T_RM2: begin
        lk_we    = 1'b1;
        lk_waddr = FreeSlot;
        lk_wdata = k_r;
        if (tail_r == k_r) begin
          tail_nxt = p_r;
        end
        res_nxt   = sld_pkg::ST_REMOVED;
        state_nxt = sld_pkg::S_EMIT;
      end

      // read-out walk
      sld_pkg::S_R_0: begin
        lk_re     = 1'b1;
        lk_raddr  = HeadSlot;
        state_nxt = sld_pkg::S_R_K;
      end
      sld_pkg::S_R_K: begin
        if (lk_rdata == '0) begin
          res_nxt   = sld_pkg::ST_EMPTY;
          k_nxt     = '0;
          state_nxt = sld_pkg::S_EMIT;
        end else begin
          k_nxt     = lk_rdata;
          n_nxt     = '0;
          lk_re     = 1'b1;
          lk_raddr  = lk_rdata;
          vl_re     = 1'b1;
          vl_raddr  = lk_rdata;
          state_nxt = sld_pkg::S_R_EMIT;
        end
      end
      sld_pkg::S_R_EMIT: begin
        if (out_free) begin
          load      = 1'b1;
          ost_nxt   = sld_pkg::ST_ITEM;
          oslot_nxt = k_r;
          oval_nxt  = vl_rdata;
          olast_nxt = rd_last;
          if (rd_last) begin
            state_nxt = sld_pkg::S_IDLE;
          end else begin
            k_nxt    = lk_rdata;
            n_nxt    = n_inc;
            lk_re    = 1'b1;
            lk_raddr = lk_rdata;
            vl_re    = 1'b1;
            vl_raddr = lk_rdata;
          end
        end
      end

      // single-beat result
      sld_pkg::S_EMIT: begin
        if (out_free) begin
          load      = 1'b1;
          ost_nxt   = res_r;
          oslot_nxt = k_r;
          oval_nxt  = (res_r == sld_pkg::ST_EMPTY) ? '0 : v_r;
          olast_nxt = 1'b1;
          state_nxt = sld_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = sld_pkg::S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_comb begin
    out_slot           = '0;
    out_slot[AW-1:0]   = oslot_r;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = ost_r;
  assign out_elem_value = oval_r;
  assign out_last       = olast_r;

endmodule

[tb/tb_static_list_symmetric_difference.sv]
// Self-checking testbench for the static list symmetric difference block.
`timescale 1ns / 1ps
module tb_static_list_symmetric_difference;

  localparam int PoolSize = sld_pkg::PoolSizeDef;
  localparam int MaxBeats = PoolSize - 2;   // longest possible read-out
  localparam logic [sld_pkg::ModeW-1:0] ModeUnused = 2'd3;

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [sld_pkg::ModeW-1:0]  in_mode;
  logic [sld_pkg::ValueW-1:0] in_value;
  logic                       out_valid;
  logic                       out_ready;
  logic [sld_pkg::StatusW-1:0] out_status;
  logic [sld_pkg::SlotW-1:0]  out_slot;
  logic [sld_pkg::ValueW-1:0] out_elem_value;
  logic                       out_last;

  static_list_symmetric_difference #(
    .POOL_SIZE(PoolSize)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_slot      (out_slot),
    .out_elem_value(out_elem_value),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow list: own copy of the link RAM, values and set tail
  // --------------------------------------------------------------------------
  typedef struct packed {
    sld_pkg::status_t           status;
    logic [sld_pkg::SlotW-1:0]  slot;
    logic [sld_pkg::ValueW-1:0] elem;
    logic                       last;
  } beat_t;

  logic [sld_pkg::SlotW-1:0]  nxt_slot [PoolSize];
  logic [sld_pkg::ValueW-1:0] slot_val [PoolSize];
  logic [sld_pkg::SlotW-1:0]  set_end;
  beat_t                      pending_beats [$];

  int n_cmds, n_beats, n_full, n_removed, n_inserted, n_empty, n_dropped, longest_read;
  int n_errors;
  bit calm;          // no idling on either side while set
  int hold_req;      // long receiver hold-off requested by the stimulus

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #(20_000_000);
    $display("timeout: %0d result beats still outstanding", pending_beats.size());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void queue_beat(sld_pkg::status_t st, logic [sld_pkg::SlotW-1:0] s,
                                     logic [sld_pkg::ValueW-1:0] v, logic l);
    beat_t b;
    b.status = st;
    b.slot   = s;
    b.elem   = v;
    b.last   = l;
    pending_beats.push_back(b);
  endfunction

  // Pop the free chain head; 0 means the pool is exhausted.
  function automatic logic [sld_pkg::SlotW-1:0] grab_free();
    logic [sld_pkg::SlotW-1:0] s;
    s = nxt_slot[0];
    if (s != '0) nxt_slot[0] = nxt_slot[s];
    return s;
  endfunction

  function automatic void link_after_end(logic [sld_pkg::SlotW-1:0] s,
                                         logic [sld_pkg::ValueW-1:0] v);
    slot_val[s] = v;
    nxt_slot[s] = nxt_slot[set_end];
    nxt_slot[set_end] = s;
  endfunction

  // Apply one accepted command to the shadow list and queue its result beats.
  function automatic void list_apply(logic [sld_pkg::ModeW-1:0] m,
                                     logic [sld_pkg::ValueW-1:0] v);
    logic [sld_pkg::SlotW-1:0] s, p, k, stop;
    int n;
    case (m)
      sld_pkg::ModeAppend: begin
        s = grab_free();
        if (s == '0) begin
          queue_beat(sld_pkg::ST_FULL, '0, v, 1'b1);
          n_full++;
        end else begin
          link_after_end(s, v);
          set_end = s;
          queue_beat(sld_pkg::ST_APPENDED, s, v, 1'b1);
        end
      end
      sld_pkg::ModeToggle: begin
        // search head .. set_end only; stop is the node just past the first set
        stop = nxt_slot[set_end];
        p = 6'd1;
        k = nxt_slot[1];
        n = 0;
        while (k != stop && slot_val[k] != v && n < PoolSize) begin
          p = k;
          k = nxt_slot[k];
          n++;
        end
        if (k == stop || n >= PoolSize || k < 2) begin
          s = grab_free();
          if (s == '0) begin
            queue_beat(sld_pkg::ST_FULL, '0, v, 1'b1);
            n_full++;
          end else begin
            link_after_end(s, v);
            queue_beat(sld_pkg::ST_INSERTED, s, v, 1'b1);
            n_inserted++;
          end
        end else begin
          nxt_slot[p] = nxt_slot[k];
          nxt_slot[k] = nxt_slot[0];
          nxt_slot[0] = k;
          if (set_end == k) set_end = p;
          queue_beat(sld_pkg::ST_REMOVED, k, v, 1'b1);
          n_removed++;
        end
      end
      sld_pkg::ModeRead: begin
        k = nxt_slot[1];
        if (k == '0) begin
          queue_beat(sld_pkg::ST_EMPTY, '0, '0, 1'b1);
          n_empty++;
        end else begin
          n = 0;
          while (k != '0 && n < MaxBeats) begin
            queue_beat(sld_pkg::ST_ITEM, k, slot_val[k],
                       (nxt_slot[k] == '0) || (n + 1 == MaxBeats));
            n++;
            k = nxt_slot[k];
          end
          if (n > longest_read) longest_read = n;
        end
      end
      default: begin
        n_dropped++;  // unused mode: dropped, nothing comes back
      end
    endcase
  endfunction

  // Random value out of the list (first set only, or the whole list).
  function automatic logic [sld_pkg::ValueW-1:0] draw_listed_value(bit first_only,
                                                                   output bit found);
    logic [sld_pkg::SlotW-1:0] k;
    int n, want, idx;
    logic [sld_pkg::ValueW-1:0] v;
    n = 0;
    v = '0;
    if (!(first_only && set_end == 6'd1)) begin
      k = nxt_slot[1];
      while (k != '0 && n < PoolSize) begin
        n++;
        if (first_only && k == set_end) break;
        k = nxt_slot[k];
      end
    end
    found = (n != 0);
    if (found) begin
      want = $urandom_range(0, n - 1);
      k = nxt_slot[1];
      for (idx = 0; idx < want; idx++) k = nxt_slot[k];
      v = slot_val[k];
    end
    return v;
  endfunction

  // Small values collide often and so exercise the match path; the rest are wide.
  function automatic logic [sld_pkg::ValueW-1:0] draw_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return sld_pkg::ValueW'($urandom_range(0, 15));
    if (r < 58) return {1'b1, 31'($urandom_range(0, 3))};
    return sld_pkg::ValueW'($urandom());
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int draw_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= 30) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off on request, field check
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    beat_t want;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        n_beats++;
        if (pending_beats.size() == 0) begin
          flag_error($sformatf("unexpected beat status %0d slot %0d value %h",
                               out_status, out_slot, out_elem_value));
        end else begin
          want = pending_beats.pop_front();
          if (out_status != want.status)
            flag_error($sformatf("status %0d, want %0d (slot %0d)",
                                 out_status, want.status, want.slot));
          if (out_slot != want.slot)
            flag_error($sformatf("slot %0d, want %0d", out_slot, want.slot));
          if (out_elem_value != want.elem)
            flag_error($sformatf("value %h, want %h (slot %0d)",
                                 out_elem_value, want.elem, want.slot));
          if (out_last != want.last)
            flag_error($sformatf("last %b, want %b (slot %0d)",
                                 out_last, want.last, want.slot));
        end
      end
      if (hold_req > 0) begin
        stall = hold_req;   // long hold-off: block backs up and drops in_ready
        hold_req = 0;
      end else if (stall == 0 && $urandom_range(0, 99) < 35) begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  // Offer one command and hold it until accepted; the shadow is updated on accept.
  task automatic offer_cmd(input logic [sld_pkg::ModeW-1:0] m,
                           input logic [sld_pkg::ValueW-1:0] v);
    in_valid <= 1'b1;
    in_mode  <= m;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    list_apply(m, v);
    if (m != ModeUnused) n_cmds++;
  endtask

  task automatic idle_gap();
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  typedef struct packed {
    logic [sld_pkg::ModeW-1:0]  mode;
    logic [sld_pkg::ValueW-1:0] value;
    bit                         pinned;   // expected beat typed in below
    sld_pkg::status_t           status;
    logic [sld_pkg::SlotW-1:0]  slot;
    logic [sld_pkg::ValueW-1:0] elem;
  } plan_row_t;

  plan_row_t plan [$];

  // Row checked against the shadow list.
  function automatic void add_row(logic [sld_pkg::ModeW-1:0] m,
                                  logic [sld_pkg::ValueW-1:0] v);
    plan_row_t row;
    row        = '0;
    row.mode   = m;
    row.value  = v;
    row.pinned = 1'b0;
    row.status = sld_pkg::ST_APPENDED;
    plan.push_back(row);
  endfunction

  // Row with its single result beat typed in.
  function automatic void add_pin(logic [sld_pkg::ModeW-1:0] m,
                                  logic [sld_pkg::ValueW-1:0] v,
                                  sld_pkg::status_t st,
                                  logic [sld_pkg::SlotW-1:0] s,
                                  logic [sld_pkg::ValueW-1:0] e);
    plan_row_t row;
    row.mode   = m;
    row.value  = v;
    row.pinned = 1'b1;
    row.status = st;
    row.slot   = s;
    row.elem   = e;
    plan.push_back(row);
  endfunction

  initial begin : stimulus
    int round, got, r, a_pct, t_pct, rd_pct;
    logic [sld_pkg::ModeW-1:0] m;
    logic [sld_pkg::ValueW-1:0] v;
    bit found;
    beat_t pinned_beat;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_mode  = sld_pkg::ModeAppend;
    in_value = '0;
    calm     = 1'b0;
    hold_req = 0;
    n_cmds = 0; n_beats = 0; n_errors = 0; longest_read = 0;
    n_full = 0; n_removed = 0; n_inserted = 0; n_empty = 0; n_dropped = 0;

    for (int i = 0; i < PoolSize; i++) begin
      nxt_slot[i] = (i + 1 < PoolSize) ? sld_pkg::SlotW'(i + 1) : '0;
      slot_val[i] = '0;
    end
    nxt_slot[0] = 6'd2;
    nxt_slot[1] = '0;
    set_end = 6'd1;

    // Directed walk. Pinned rows follow straight from the reset free chain.
    add_pin(sld_pkg::ModeRead,   32'h0,        sld_pkg::ST_EMPTY,    6'd0, 32'h0);
    // toggle with an empty first set lands after the head
    add_pin(sld_pkg::ModeToggle, 32'd5,        sld_pkg::ST_INSERTED, 6'd2, 32'd5);
    add_pin(sld_pkg::ModeAppend, 32'h7FFFFFFF, sld_pkg::ST_APPENDED, 6'd3, 32'h7FFFFFFF);
    add_pin(sld_pkg::ModeAppend, 32'h80000000, sld_pkg::ST_APPENDED, 6'd4, 32'h80000000);
    add_pin(sld_pkg::ModeAppend, 32'h0,        sld_pkg::ST_APPENDED, 6'd5, 32'h0);
    add_pin(sld_pkg::ModeAppend, 32'hFFFFFFFF, sld_pkg::ST_APPENDED, 6'd6, 32'hFFFFFFFF);
    // 5 sits past the set tail, so it is not found and goes in again
    add_row(sld_pkg::ModeToggle, 32'd5);
    add_row(sld_pkg::ModeRead,   32'h0);
    add_row(sld_pkg::ModeToggle, 32'h80000000);
    // removing the tail node pulls the tail back
    add_row(sld_pkg::ModeToggle, 32'hFFFFFFFF);
    add_row(sld_pkg::ModeToggle, 32'h7FFFFFFF);
    add_row(ModeUnused,          32'hDEADBEEF);
    add_row(sld_pkg::ModeAppend, 32'h55555555);
    add_row(sld_pkg::ModeAppend, 32'hAAAAAAAA);
    add_row(sld_pkg::ModeAppend, 32'hAAAAAAAA);
    // duplicate: only the first occurrence goes
    add_row(sld_pkg::ModeToggle, 32'hAAAAAAAA);
    add_row(sld_pkg::ModeRead,   32'h0);
    add_row(sld_pkg::ModeToggle, 32'h0);
    add_row(sld_pkg::ModeToggle, 32'h55555555);
    add_row(sld_pkg::ModeToggle, 32'hAAAAAAAA);
    add_row(sld_pkg::ModeToggle, 32'h12345678);
    add_row(sld_pkg::ModeRead,   32'h0);
    add_row(ModeUnused,          32'hFFFFFFFF);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      offer_cmd(plan[i].mode, plan[i].value);
      if (plan[i].pinned) begin
        // swap the shadow's beat for the hand-written one before it can come out
        void'(pending_beats.pop_back());
        pinned_beat.status = plan[i].status;
        pinned_beat.slot   = plan[i].slot;
        pinned_beat.elem   = plan[i].elem;
        pinned_beat.last   = 1'b1;
        pending_beats.push_back(pinned_beat);
      end
      idle_gap();
    end

    // Random rounds: fill, fill to exhaustion, drain and mixed traffic.
    for (round = 0; round < 8; round++) begin
      case (round % 4)
        0:       begin a_pct = 55; t_pct = 30; rd_pct = 12; end
        1:       begin a_pct = 85; t_pct = 7;  rd_pct = 6;  end
        2:       begin a_pct = 10; t_pct = 78; rd_pct = 10; end
        default: begin a_pct = 40; t_pct = 45; rd_pct = 12; end
      endcase
      if (round == 0) begin a_pct = 55; end
      if (round == 7) begin a_pct = 85; t_pct = 7; rd_pct = 6; end
      calm = (round == 3 || round == 6);
      if (round == 1 || round == 5) hold_req = 400;
      got = 0;
      while (got < 42) begin
        r = $urandom_range(0, 99);
        if (r < a_pct) begin
          m = sld_pkg::ModeAppend;
          v = draw_value();
        end else if (r < a_pct + t_pct) begin
          m = sld_pkg::ModeToggle;
          r = $urandom_range(0, 99);
          found = 1'b0;
          if (r < 65) v = draw_listed_value(1'b1, found);
          else if (r < 80) v = draw_listed_value(1'b0, found);
          if (!found) v = draw_value();
        end else if (r < a_pct + t_pct + rd_pct) begin
          m = sld_pkg::ModeRead;
          v = sld_pkg::ValueW'($urandom());
        end else begin
          m = ModeUnused;
          v = sld_pkg::ValueW'($urandom());
        end
        offer_cmd(m, v);
        idle_gap();
        if (m != ModeUnused) got++;
      end
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (pending_beats.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("run covered %0d commands (%0d unused-mode beats dropped), %0d result beats",
             n_cmds, n_dropped, n_beats);
    $display("pool full %0d, inserts %0d, removals %0d, empty reads %0d, longest read %0d",
             n_full, n_inserted, n_removed, n_empty, longest_read);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[static_list_symmetric_difference.f]
hw/rtl/sld_pkg.sv
hw/rtl/sld_ram.sv
hw/rtl/sld_link_mem.sv
hw/rtl/static_list_symmetric_difference.sv
tb/tb_static_list_symmetric_difference.sv
